/* design/est_pkg.sv */
package est_pkg;

    localparam int FACTOR_W  = 17;
    localparam int DIMS_W    = 2;
    localparam int FRAC_BITS = 16;
    localparam int N_LANES   = 3;
    localparam int Q_DEPTH   = 2;

    localparam logic [FACTOR_W-1:0] SHRINK_ONE   = 17'd65536;
    localparam logic [FACTOR_W-1:0] SHRINK_RESET = 17'd32768;
    localparam logic [DIMS_W-1:0]   DIMS_RESET   = 2'd3;
    localparam logic [DIMS_W-1:0]   DIMS_FLAT    = 2'd2;
    localparam logic [15:0]         ROUND_HALF   = 16'h8000;

    localparam logic CFG_SHRINK_FACTOR = 1'b0;
    localparam logic CFG_DIMENSIONS    = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_RUN,
        ST_DRAIN
    } t_back_state;

    typedef struct packed {
        logic rel;
        logic bank;
    } t_bank_rel;

endpackage

/* design/est_queue.sv */
module est_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2,
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW = $clog2(DEPTH + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wp;
    logic [PW-1:0]    r_rp;
    logic [CW-1:0]    r_cnt;
    logic             w_do_push;
    logic             w_do_pop;

    assign o_full    = (r_cnt == CW'(DEPTH));
    assign o_empty   = (r_cnt == '0);
    assign o_data    = r_mem[r_rp];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_do_push) begin
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + PW'(1);
            end
            if (w_do_pop) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + PW'(1);
            end
            if (w_do_push && !w_do_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (!w_do_push && w_do_pop) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

endmodule

/* design/est_front.sv */
module est_front #(
    parameter int MAX_VERTICES = 8,
    parameter int COORD_WIDTH  = 32,
    localparam int CNW = $clog2(MAX_VERTICES + 1),
    localparam int IW  = $clog2(MAX_VERTICES),
    localparam int AW  = $clog2(2 * MAX_VERTICES),
    localparam int SW  = COORD_WIDTH + $clog2(MAX_VERTICES),
    localparam int MW  = 3 * COORD_WIDTH + 1,
    localparam int DW  = 2 + CNW + 3 * SW
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [COORD_WIDTH-1:0] i_coord_x,
    input  logic signed [COORD_WIDTH-1:0] i_coord_y,
    input  logic signed [COORD_WIDTH-1:0] i_coord_z,
    input  logic                          i_vertex_valid,
    input  logic                          i_element_end,
    input  logic                          i_flat,
    output logic                          o_push,
    output logic [DW-1:0]                 o_desc,
    input  logic                          i_q_full,
    output logic                          o_wr_en,
    output logic [AW-1:0]                 o_wr_addr,
    output logic [MW-1:0]                 o_wr_data,
    input  est_pkg::t_bank_rel            i_rel
);
    import est_pkg::*;

    logic                   r_bank;
    logic [1:0]             r_busy;
    logic [1:0]             n_busy;
    logic [CNW-1:0]         r_cnt;
    logic                   r_ovf;
    logic signed [SW-1:0]   r_sum [N_LANES];
    logic signed [SW-1:0]   n_sum [N_LANES];
    logic [CNW-1:0]         n_cnt;
    logic                   n_ovf;
    logic                   w_accept;
    logic                   w_store;
    logic [COORD_WIDTH-1:0] w_coord [N_LANES];
    logic [AW-1:0]          w_idx;

    assign o_stall    = r_busy[r_bank] || i_q_full;
    assign w_accept   = i_valid && !o_stall;
    assign w_store    = w_accept && (r_cnt < CNW'(MAX_VERTICES));
    assign w_coord[0] = i_coord_x;
    assign w_coord[1] = i_coord_y;
    assign w_coord[2] = i_flat ? '0 : i_coord_z;
    assign w_idx      = AW'(r_cnt[IW-1:0]);

    always_comb begin
        for (int l = 0; l < N_LANES; l++) begin
            n_sum[l] = r_sum[l];
            if (w_store) begin
                n_sum[l] = r_sum[l]
                    + {{(SW - COORD_WIDTH){w_coord[l][COORD_WIDTH-1]}}, w_coord[l]};
            end
        end
    end

    always_comb begin
        n_busy = r_busy;
        if (i_rel.rel) begin
            n_busy[i_rel.bank] = 1'b0;
        end
        if (o_push) begin
            n_busy[r_bank] = 1'b1;
        end
    end

    assign n_cnt = r_cnt + CNW'(w_store);
    assign n_ovf = r_ovf || (w_accept && !w_store);

    assign o_push    = w_accept && i_element_end;
    assign o_desc    = {r_bank, n_ovf, n_cnt, n_sum[2], n_sum[1], n_sum[0]};
    assign o_wr_en   = w_store;
    assign o_wr_addr = r_bank ? AW'(MAX_VERTICES) + w_idx : w_idx;
    assign o_wr_data = {i_vertex_valid, w_coord[2], w_coord[1], w_coord[0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bank <= 1'b0;
            r_busy <= '0;
            r_cnt  <= '0;
            r_ovf  <= 1'b0;
            for (int l = 0; l < N_LANES; l++) begin
                r_sum[l] <= '0;
            end
        end else begin
            r_busy <= n_busy;
            if (o_push) begin
                r_bank         <= !r_bank;
                r_cnt          <= '0;
                r_ovf          <= 1'b0;
                for (int l = 0; l < N_LANES; l++) begin
                    r_sum[l] <= '0;
                end
            end else if (w_accept) begin
                r_cnt <= n_cnt;
                r_ovf <= n_ovf;
                for (int l = 0; l < N_LANES; l++) begin
                    r_sum[l] <= n_sum[l];
                end
            end
        end
    end

endmodule

/* design/est_back.sv */
module est_back #(
    parameter int MAX_VERTICES = 8,
    parameter int COORD_WIDTH  = 32,
    localparam int CNW = $clog2(MAX_VERTICES + 1),
    localparam int IW  = $clog2(MAX_VERTICES),
    localparam int AW  = $clog2(2 * MAX_VERTICES),
    localparam int SW  = COORD_WIDTH + $clog2(MAX_VERTICES),
    localparam int MW  = 3 * COORD_WIDTH + 1,
    localparam int DW  = 2 + CNW + 3 * SW,
    localparam int STW = $clog2(SW + 1),
    localparam int DFW = COORD_WIDTH + 1,
    localparam int PW  = DFW + est_pkg::FACTOR_W,
    localparam int QW  = PW - est_pkg::FRAC_BITS,
    localparam int RW  = COORD_WIDTH + 3
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_desc_valid,
    input  logic [DW-1:0]                 i_desc,
    output logic                          o_desc_pop,
    input  logic                          i_wr_en,
    input  logic [AW-1:0]                 i_wr_addr,
    input  logic [MW-1:0]                 i_wr_data,
    input  logic [est_pkg::FACTOR_W-1:0]  i_factor,
    input  logic                          i_flat,
    output est_pkg::t_bank_rel            o_rel,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic signed [COORD_WIDTH-1:0] o_moved_x,
    output logic signed [COORD_WIDTH-1:0] o_moved_y,
    output logic signed [COORD_WIDTH-1:0] o_moved_z,
    output logic                          o_moved_valid,
    output logic                          o_run_last,
    output logic                          o_too_many_vertices
);
    import est_pkg::*;

    logic [MW-1:0] r_mem [2 * MAX_VERTICES];
    logic [MW-1:0] r_rd;

    t_back_state r_state;
    t_back_state n_state;

    logic                   r_bank;
    logic                   r_ovf;
    logic [CNW-1:0]         r_cnt;
    logic [CNW-1:0]         r_k;
    logic [STW-1:0]         r_step;
    logic                   r_neg [N_LANES];
    logic [SW-1:0]          r_div [N_LANES];
    logic [CNW-1:0]         r_rem [N_LANES];
    logic [COORD_WIDTH-1:0] r_cen [N_LANES];

    logic                   r_s1_vld, r_s1_last, r_s1_ovf;
    logic                   r_s2_vld, r_s2_last, r_s2_ovf, r_s2_mv;
    logic                   r_s3_vld, r_s3_last, r_s3_ovf, r_s3_mv;
    logic [COORD_WIDTH-1:0] r_s2_p    [N_LANES];
    logic                   r_s2_neg  [N_LANES];
    logic [DFW-1:0]         r_s2_mag  [N_LANES];
    logic [COORD_WIDTH-1:0] r_s3_p    [N_LANES];
    logic                   r_s3_neg  [N_LANES];
    logic [PW-1:0]          r_s3_prod [N_LANES];
    logic [COORD_WIDTH-1:0] r_out     [N_LANES];
    logic                   r_o_vld, r_o_last, r_o_ovf, r_o_mv;

    logic                   w_adv;
    logic                   w_rd_en;
    logic                   w_last;
    logic [CNW-1:0]         w_k_inc;
    logic [AW-1:0]          w_k_idx;
    logic [AW-1:0]          w_rd_addr;
    logic [FACTOR_W-1:0]    w_f;
    logic [CNW:0]           w_trial   [N_LANES];
    logic                   w_ge      [N_LANES];
    logic [CNW-1:0]         w_rem_nx  [N_LANES];
    logic [SW-1:0]          w_d_sum   [N_LANES];
    logic [COORD_WIDTH-1:0] w_q_cen   [N_LANES];
    logic [COORD_WIDTH-1:0] w_p       [N_LANES];
    logic signed [DFW-1:0]  w_diff    [N_LANES];
    logic [PW-1:0]          w_rnd     [N_LANES];
    logic [QW-1:0]          w_q       [N_LANES];
    logic signed [RW-1:0]   w_res     [N_LANES];

    assign w_adv     = !r_o_vld || !i_stall;
    assign w_k_inc   = r_k + CNW'(1);
    assign w_last    = (w_k_inc == r_cnt);
    assign w_k_idx   = AW'(r_k[IW-1:0]);
    assign w_rd_addr = r_bank ? AW'(MAX_VERTICES) + w_k_idx : w_k_idx;
    assign w_f       = (i_factor > SHRINK_ONE) ? SHRINK_ONE : i_factor;

    assign w_d_sum[0] = i_desc[SW-1:0];
    assign w_d_sum[1] = i_desc[2*SW-1:SW];
    assign w_d_sum[2] = i_desc[3*SW-1:2*SW];

    assign w_p[0] = r_rd[COORD_WIDTH-1:0];
    assign w_p[1] = r_rd[2*COORD_WIDTH-1:COORD_WIDTH];
    assign w_p[2] = r_rd[3*COORD_WIDTH-1:2*COORD_WIDTH];

    // per-lane restoring divide step, centroid select and shrink arithmetic
    always_comb begin
        for (int l = 0; l < N_LANES; l++) begin
            w_trial[l]  = {r_rem[l], r_div[l][SW-1]};
            w_ge[l]     = (w_trial[l] >= {1'b0, r_cnt});
            w_rem_nx[l] = w_ge[l] ? CNW'(w_trial[l] - {1'b0, r_cnt})
                                  : w_trial[l][CNW-1:0];
            w_q_cen[l]  = r_div[l][COORD_WIDTH-1:0];
            w_diff[l]   = {r_cen[l][COORD_WIDTH-1], r_cen[l]}
                        - {w_p[l][COORD_WIDTH-1], w_p[l]};
            w_rnd[l]    = r_s3_prod[l] + PW'(ROUND_HALF);
            w_q[l]      = w_rnd[l][PW-1:FRAC_BITS];
            w_res[l]    = r_s3_neg[l]
                ? {{3{r_s3_p[l][COORD_WIDTH-1]}}, r_s3_p[l]} - RW'({1'b0, w_q[l]})
                : {{3{r_s3_p[l][COORD_WIDTH-1]}}, r_s3_p[l]} + RW'({1'b0, w_q[l]});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_desc_pop = 1'b0;
        w_rd_en    = 1'b0;
        o_rel.rel  = 1'b0;
        o_rel.bank = r_bank;
        case (r_state)
            ST_IDLE: begin
                if (i_desc_valid) begin
                    o_desc_pop = 1'b1;
                    n_state    = ST_DIV;
                end
            end
            ST_DIV: begin
                if (r_step == STW'(SW)) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (w_adv) begin
                    w_rd_en = 1'b1;
                    if (w_last) begin
                        o_rel.rel = 1'b1;
                        n_state   = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN: begin
                if (!r_s1_vld && !r_s2_vld && !r_s3_vld) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rd_en) begin
            r_rd <= r_mem[w_rd_addr];
        end
    end

    // element setup and centroid divide
    always_ff @(posedge i_clk) begin
        if (o_desc_pop) begin
            r_bank <= i_desc[DW-1];
            r_ovf  <= i_desc[DW-2];
            r_cnt  <= i_desc[3*SW+CNW-1:3*SW];
            r_step <= '0;
            r_k    <= '0;
            for (int l = 0; l < N_LANES; l++) begin
                r_neg[l] <= w_d_sum[l][SW-1];
                r_rem[l] <= '0;
                r_div[l] <= (w_d_sum[l][SW-1] ? SW'(-w_d_sum[l]) : w_d_sum[l])
                          + SW'(i_desc[3*SW+CNW-1:3*SW+1]);
            end
        end else if (r_state == ST_DIV) begin
            if (r_step == STW'(SW)) begin
                for (int l = 0; l < N_LANES; l++) begin
                    r_cen[l] <= r_neg[l] ? -w_q_cen[l] : w_q_cen[l];
                end
            end else begin
                r_step <= r_step + STW'(1);
                for (int l = 0; l < N_LANES; l++) begin
                    r_rem[l] <= w_rem_nx[l];
                    r_div[l] <= {r_div[l][SW-2:0], w_ge[l]};
                end
            end
        end else if (w_rd_en) begin
            r_k <= w_k_inc;
        end
    end

    // result pipeline: read, difference, multiply, round and output
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
            r_o_vld  <= 1'b0;
        end else if (w_adv) begin
            r_s1_vld <= w_rd_en;
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= r_s2_vld;
            r_o_vld  <= r_s3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_last <= w_last;
            r_s1_ovf  <= r_ovf;
            r_s2_last <= r_s1_last;
            r_s2_ovf  <= r_s1_ovf;
            r_s2_mv   <= r_rd[MW-1];
            r_s3_last <= r_s2_last;
            r_s3_ovf  <= r_s2_ovf;
            r_s3_mv   <= r_s2_mv;
            r_o_last  <= r_s3_last;
            r_o_ovf   <= r_s3_ovf;
            r_o_mv    <= r_s3_mv;
            for (int l = 0; l < N_LANES; l++) begin
                r_s2_p[l]    <= w_p[l];
                r_s2_neg[l]  <= w_diff[l][DFW-1];
                r_s2_mag[l]  <= w_diff[l][DFW-1] ? DFW'(-w_diff[l]) : DFW'(w_diff[l]);
                r_s3_p[l]    <= r_s2_p[l];
                r_s3_neg[l]  <= r_s2_neg[l];
                r_s3_prod[l] <= PW'(r_s2_mag[l]) * PW'(w_f);
                r_out[l]     <= (l == 2 && i_flat) ? '0 : w_res[l][COORD_WIDTH-1:0];
            end
        end
    end

    assign o_valid             = r_o_vld;
    assign o_moved_x           = r_out[0];
    assign o_moved_y           = r_out[1];
    assign o_moved_z           = r_out[2];
    assign o_moved_valid       = r_o_mv;
    assign o_run_last          = r_o_last;
    assign o_too_many_vertices = r_o_ovf;

endmodule

/* design/element_shrink_to_centroid.sv */
// Shrinks each mesh element toward its centroid. Vertices are accepted one per cycle into
// one of two vertex banks while summing runs alongside; the vertex marked element_end
// closes the element. The back end then divides the three sums by the vertex count with
// restoring dividers that make one quotient bit per cycle, and streams one moved vertex
// per cycle, unless the output stalls, through a four-stage read, difference, multiply
// and round pipeline, the multiply being the widest unit. While an element occupies the
// back end, the next element loads into the other bank; the input stalls only when both
// banks hold elements whose vertices the back end has not yet read.
// Configuration writes are always ready and are meant for idle periods only.
module element_shrink_to_centroid #(
    parameter int MAX_VERTICES = 8,
    parameter int COORD_WIDTH  = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic                          i_cfg_index,
    input  logic [est_pkg::FACTOR_W-1:0]  i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [COORD_WIDTH-1:0] i_coord_x,
    input  logic signed [COORD_WIDTH-1:0] i_coord_y,
    input  logic signed [COORD_WIDTH-1:0] i_coord_z,
    input  logic                          i_vertex_valid,
    input  logic                          i_element_end,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic signed [COORD_WIDTH-1:0] o_moved_x,
    output logic signed [COORD_WIDTH-1:0] o_moved_y,
    output logic signed [COORD_WIDTH-1:0] o_moved_z,
    output logic                          o_moved_valid,
    output logic                          o_run_last,
    output logic                          o_too_many_vertices
);
    import est_pkg::*;

    localparam int CNW = $clog2(MAX_VERTICES + 1);
    localparam int AW  = $clog2(2 * MAX_VERTICES);
    localparam int SW  = COORD_WIDTH + $clog2(MAX_VERTICES);
    localparam int MW  = 3 * COORD_WIDTH + 1;
    localparam int DW  = 2 + CNW + 3 * SW;

    logic [FACTOR_W-1:0] r_shrink_factor;
    logic [DIMS_W-1:0]   r_dimensions;
    logic                w_flat;
    logic                w_push;
    logic                w_pop;
    logic                w_q_full;
    logic                w_q_empty;
    logic [DW-1:0]       w_desc_in;
    logic [DW-1:0]       w_desc_out;
    logic                w_wr_en;
    logic [AW-1:0]       w_wr_addr;
    logic [MW-1:0]       w_wr_data;
    t_bank_rel           w_rel;

    assign o_cfg_ready = 1'b1;
    assign w_flat      = (r_dimensions == DIMS_FLAT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shrink_factor <= SHRINK_RESET;
            r_dimensions    <= DIMS_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_SHRINK_FACTOR: r_shrink_factor <= i_cfg_data;
                CFG_DIMENSIONS:    r_dimensions    <= i_cfg_data[DIMS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    est_front #(
        .MAX_VERTICES (MAX_VERTICES),
        .COORD_WIDTH  (COORD_WIDTH)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_coord_x      (i_coord_x),
        .i_coord_y      (i_coord_y),
        .i_coord_z      (i_coord_z),
        .i_vertex_valid (i_vertex_valid),
        .i_element_end  (i_element_end),
        .i_flat         (w_flat),
        .o_push         (w_push),
        .o_desc         (w_desc_in),
        .i_q_full       (w_q_full),
        .o_wr_en        (w_wr_en),
        .o_wr_addr      (w_wr_addr),
        .o_wr_data      (w_wr_data),
        .i_rel          (w_rel)
    );

    est_queue #(
        .WIDTH (DW),
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_desc_in),
        .o_full  (w_q_full),
        .i_pop   (w_pop),
        .o_data  (w_desc_out),
        .o_empty (w_q_empty)
    );

    est_back #(
        .MAX_VERTICES (MAX_VERTICES),
        .COORD_WIDTH  (COORD_WIDTH)
    ) u_back (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_desc_valid        (!w_q_empty),
        .i_desc              (w_desc_out),
        .o_desc_pop          (w_pop),
        .i_wr_en             (w_wr_en),
        .i_wr_addr           (w_wr_addr),
        .i_wr_data           (w_wr_data),
        .i_factor            (r_shrink_factor),
        .i_flat              (w_flat),
        .o_rel               (w_rel),
        .o_valid             (o_valid),
        .i_stall             (i_stall),
        .o_moved_x           (o_moved_x),
        .o_moved_y           (o_moved_y),
        .o_moved_z           (o_moved_z),
        .o_moved_valid       (o_moved_valid),
        .o_run_last          (o_run_last),
        .o_too_many_vertices (o_too_many_vertices)
    );

    a_push_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_q_full)
        else $error("element pushed into full queue");

    a_pop_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_q_empty)
        else $error("element popped from empty queue");

    a_bank_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && w_rel.rel) |-> (w_desc_in[DW-1] != w_rel.bank))
        else $error("bank closed by front while released by back");

endmodule

/* tb/shrink_check.sv */
`timescale 1ns / 100ps

module shrink_check #(
    parameter int MAX_VERTICES = 8,
    parameter int COORD_WIDTH  = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_valid,
    input  logic                                 i_cfg_ready,
    input  logic                                 i_cfg_index,
    input  logic [est_pkg::FACTOR_W-1:0]         i_cfg_data,
    input  logic                                 i_in_valid,
    input  logic                                 i_in_stall,
    input  logic signed [COORD_WIDTH-1:0]        i_coord_x,
    input  logic signed [COORD_WIDTH-1:0]        i_coord_y,
    input  logic signed [COORD_WIDTH-1:0]        i_coord_z,
    input  logic                                 i_vertex_valid,
    input  logic                                 i_element_end,
    input  logic                                 i_out_valid,
    input  logic                                 i_out_stall,
    input  logic signed [COORD_WIDTH-1:0]        i_moved_x,
    input  logic signed [COORD_WIDTH-1:0]        i_moved_y,
    input  logic signed [COORD_WIDTH-1:0]        i_moved_z,
    input  logic                                 i_moved_valid,
    input  logic                                 i_run_last,
    input  logic                                 i_too_many_vertices,
    output int                                   o_errors,
    output int                                   o_pending
);

    import est_pkg::*;

    typedef struct packed {
        logic [COORD_WIDTH-1:0] x;
        logic [COORD_WIDTH-1:0] y;
        logic [COORD_WIDTH-1:0] z;
        logic                   valid;
        logic                   last;
        logic                   many;
    } t_moved_vertex;

    logic [FACTOR_W-1:0]           factor_reg;
    logic [DIMS_W-1:0]             dims_reg;
    logic signed [COORD_WIDTH-1:0] held_x [MAX_VERTICES];
    logic signed [COORD_WIDTH-1:0] held_y [MAX_VERTICES];
    logic signed [COORD_WIDTH-1:0] held_z [MAX_VERTICES];
    logic                          held_valid [MAX_VERTICES];
    longint                        acc_x;
    longint                        acc_y;
    longint                        acc_z;
    int                            held_count;
    logic                          dropped;
    t_moved_vertex                 moved_q[$];

    initial begin
        o_errors  = 0;
        o_pending = 0;
    end

    task automatic report_mismatch(input string what);
        $display("shrink_check: %0t: %s", $time, what);
        o_errors++;
    endtask

    // rounded mean, ties away from zero
    function automatic longint centroid_of(input longint s, input int n);
        longint mag;
        longint q;
        mag = (s < 0) ? -s : s;
        q   = (mag + n / 2) / n;
        return (s < 0) ? -q : q;
    endfunction

    // p + round((c - p) * f / one), ties away from zero
    function automatic logic [COORD_WIDTH-1:0] moved_coord(input longint p, input longint c,
                                                          input longint f);
        longint d;
        longint mag;
        longint q;
        longint res;
        d   = c - p;
        mag = (d < 0) ? -d : d;
        q   = (mag >>> FRAC_BITS) * f
            + (((mag % (longint'(1) << FRAC_BITS)) * f + (longint'(1) << (FRAC_BITS - 1)))
               >>> FRAC_BITS);
        res = (d < 0) ? p - q : p + q;
        return res[COORD_WIDTH-1:0];
    endfunction

    task automatic absorb_vertex();
        logic          flat;
        longint        f;
        longint        cx;
        longint        cy;
        longint        cz;
        t_moved_vertex mv;
        flat = (dims_reg == DIMS_FLAT);
        if (held_count < MAX_VERTICES) begin
            held_x[held_count]     = i_coord_x;
            held_y[held_count]     = i_coord_y;
            held_z[held_count]     = flat ? '0 : i_coord_z;
            held_valid[held_count] = i_vertex_valid;
            acc_x += longint'(i_coord_x);
            acc_y += longint'(i_coord_y);
            acc_z += flat ? 64'sd0 : longint'(i_coord_z);
            held_count++;
        end else begin
            dropped = 1'b1;
        end
        if (!i_element_end) return;
        f  = longint'((factor_reg > SHRINK_ONE) ? SHRINK_ONE : factor_reg);
        cx = centroid_of(acc_x, held_count);
        cy = centroid_of(acc_y, held_count);
        cz = centroid_of(acc_z, held_count);
        for (int k = 0; k < held_count; k++) begin
            mv.x     = moved_coord(longint'(held_x[k]), cx, f);
            mv.y     = moved_coord(longint'(held_y[k]), cy, f);
            mv.z     = flat ? '0 : moved_coord(longint'(held_z[k]), cz, f);
            mv.valid = held_valid[k];
            mv.last  = (k == held_count - 1);
            mv.many  = dropped;
            moved_q.push_back(mv);
        end
        acc_x      = 0;
        acc_y      = 0;
        acc_z      = 0;
        held_count = 0;
        dropped    = 1'b0;
    endtask

    task automatic check_moved();
        t_moved_vertex want;
        if (moved_q.size() == 0) begin
            report_mismatch("result item with none expected");
            return;
        end
        want = moved_q.pop_front();
        if (i_moved_x !== want.x)
            report_mismatch($sformatf("moved_x got %h want %h", i_moved_x, want.x));
        if (i_moved_y !== want.y)
            report_mismatch($sformatf("moved_y got %h want %h", i_moved_y, want.y));
        if (i_moved_z !== want.z)
            report_mismatch($sformatf("moved_z got %h want %h", i_moved_z, want.z));
        if (i_moved_valid !== want.valid)
            report_mismatch($sformatf("moved_valid got %b want %b", i_moved_valid, want.valid));
        if (i_run_last !== want.last)
            report_mismatch($sformatf("run_last got %b want %b", i_run_last, want.last));
        if (i_too_many_vertices !== want.many)
            report_mismatch($sformatf("too_many_vertices got %b want %b",
                                      i_too_many_vertices, want.many));
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            factor_reg = SHRINK_RESET;
            dims_reg   = DIMS_RESET;
            acc_x      = 0;
            acc_y      = 0;
            acc_z      = 0;
            held_count = 0;
            dropped    = 1'b0;
            moved_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_SHRINK_FACTOR) begin
                    factor_reg = i_cfg_data;
                end else begin
                    dims_reg = i_cfg_data[DIMS_W-1:0];
                end
            end
            if (i_out_valid && !i_out_stall) check_moved();
            if (i_in_valid && !i_in_stall) absorb_vertex();
        end
        o_pending = moved_q.size();
    end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps

module testbench;

    import est_pkg::*;

    localparam int MAX_VERTS     = 8;
    localparam int CW            = 32;
    localparam int SETTLE_CYCLES = 100;
    localparam int HOLD_CYCLES   = 400;
    localparam int RANDOM_ITEMS  = 216;
    localparam int N_PHASES      = 8;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic                 i_cfg_index;
    logic [FACTOR_W-1:0]  i_cfg_data;
    logic                 i_valid;
    logic                 o_stall;
    logic signed [CW-1:0] i_coord_x;
    logic signed [CW-1:0] i_coord_y;
    logic signed [CW-1:0] i_coord_z;
    logic                 i_vertex_valid;
    logic                 i_element_end;
    logic                 o_valid;
    logic                 i_stall;
    logic signed [CW-1:0] o_moved_x;
    logic signed [CW-1:0] o_moved_y;
    logic signed [CW-1:0] o_moved_z;
    logic                 o_moved_valid;
    logic                 o_run_last;
    logic                 o_too_many_vertices;

    int errors;
    int pending;
    int items_sent;
    bit hold_req;

    element_shrink_to_centroid #(
        .MAX_VERTICES(MAX_VERTS),
        .COORD_WIDTH (CW)
    ) i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_coord_x          (i_coord_x),
        .i_coord_y          (i_coord_y),
        .i_coord_z          (i_coord_z),
        .i_vertex_valid     (i_vertex_valid),
        .i_element_end      (i_element_end),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_moved_x          (o_moved_x),
        .o_moved_y          (o_moved_y),
        .o_moved_z          (o_moved_z),
        .o_moved_valid      (o_moved_valid),
        .o_run_last         (o_run_last),
        .o_too_many_vertices(o_too_many_vertices)
    );

    shrink_check #(
        .MAX_VERTICES(MAX_VERTS),
        .COORD_WIDTH (CW)
    ) u_check (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_valid        (i_cfg_valid),
        .i_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_in_valid         (i_valid),
        .i_in_stall         (o_stall),
        .i_coord_x          (i_coord_x),
        .i_coord_y          (i_coord_y),
        .i_coord_z          (i_coord_z),
        .i_vertex_valid     (i_vertex_valid),
        .i_element_end      (i_element_end),
        .i_out_valid        (o_valid),
        .i_out_stall        (i_stall),
        .i_moved_x          (o_moved_x),
        .i_moved_y          (o_moved_y),
        .i_moved_z          (o_moved_z),
        .i_moved_valid      (o_moved_valid),
        .i_run_last         (o_run_last),
        .i_too_many_vertices(o_too_many_vertices),
        .o_errors           (errors),
        .o_pending          (pending)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    initial begin
        #20_000_000;
        $display("testbench: FAIL");
        $finish;
    end

    // receiver: random stall bursts, long hold on request
    initial begin
        int stall_left;
        int free_left;
        int r;
        i_stall    = 1'b0;
        stall_left = 0;
        free_left  = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req   = 1'b0;
                stall_left = HOLD_CYCLES;
                free_left  = 0;
            end
            if (stall_left == 0 && free_left == 0) begin
                r = $urandom_range(0, 99);
                if (r < 10) begin
                    free_left = $urandom_range(50, 150);
                end else begin
                    free_left = $urandom_range(1, 8);
                end
                r = $urandom_range(0, 99);
                if (r < 40) begin
                    stall_left = 0;
                end else if (r < 92) begin
                    stall_left = $urandom_range(1, 3);
                end else begin
                    stall_left = $urandom_range(15, 60);
                end
            end
            if (stall_left > 0) begin
                i_stall <= 1'b1;
                stall_left--;
            end else begin
                i_stall <= 1'b0;
                free_left--;
            end
        end
    end

    function automatic int gap_len(input bit burst);
        int r;
        if (burst) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [CW-1:0] rand_coord();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 32'h7fff_ffff;
        if (r == 1) return 32'h8000_0000;
        if (r == 2) return $urandom_range(0, 1 << 20) - (1 << 19);
        return $urandom;
    endfunction

    task automatic send_vertex(input logic [CW-1:0] x, input logic [CW-1:0] y,
                               input logic [CW-1:0] z, input logic vld, input logic last);
        @(negedge i_clk);
        i_valid        <= 1'b1;
        i_coord_x      <= x;
        i_coord_y      <= y;
        i_coord_z      <= z;
        i_vertex_valid <= vld;
        i_element_end  <= last;
        do @(posedge i_clk); while (o_stall);
        items_sent++;
    endtask

    task automatic pause_sender(input int n);
        if (n > 0) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat (n - 1) @(negedge i_clk);
        end
    endtask

    task automatic send_element(input int n, input bit burst);
        for (int i = 0; i < n; i++) begin
            send_vertex(rand_coord(), rand_coord(), rand_coord(), 1'($urandom_range(0, 1)),
                        i == n - 1);
            pause_sender(gap_len(burst));
        end
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_cfg(input logic idx, input logic [FACTOR_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [FACTOR_W-1:0] factors [N_PHASES];
        logic [DIMS_W-1:0]   dims [N_PHASES];
        int                  phase_start;
        int                  n;
        int                  r;
        bit                  burst;
        factors = '{17'd65536, 17'd0, 17'd131071, 17'd1, 17'd65535, 17'd32768, 17'd98304,
                    17'd0};
        dims    = '{2'd3, 2'd2, 2'd3, 2'd0, 2'd1, 2'd2, 2'd3, 2'd2};
        factors[7] = 17'($urandom_range(0, 65536));
        dims[7]    = 2'($urandom_range(0, 3));
        i_rst_n        = 1'b0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = CFG_SHRINK_FACTOR;
        i_cfg_data     = '0;
        i_valid        = 1'b0;
        i_coord_x      = '0;
        i_coord_y      = '0;
        i_coord_z      = '0;
        i_vertex_valid = 1'b0;
        i_element_end  = 1'b0;
        items_sent     = 0;
        hold_req       = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (SETTLE_CYCLES) @(negedge i_clk);

        write_cfg(CFG_SHRINK_FACTOR, SHRINK_RESET);
        write_cfg(CFG_DIMENSIONS, FACTOR_W'(DIMS_RESET));

        // single vertex at the coordinate extremes
        send_vertex(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 1'b1, 1'b1);
        pause_sender(gap_len(1'b0));
        // two opposite extremes
        send_vertex(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 1'b1, 1'b0);
        send_vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0, 1'b1);
        pause_sender(gap_len(1'b0));
        // small values around rounding ties
        send_vertex(32'sd1, -32'sd1, 32'sd3, 1'b1, 1'b0);
        send_vertex(32'sd2, -32'sd2, 32'sd0, 1'b0, 1'b0);
        send_vertex(32'sd0, 32'sd0, -32'sd1, 1'b1, 1'b1);
        // full element, then one that overflows and drops its last two vertices
        send_element(MAX_VERTS, 1'b0);
        send_element(MAX_VERTS + 2, 1'b1);
        wait_drained();

        for (int p = 0; p < N_PHASES; p++) begin
            write_cfg(CFG_SHRINK_FACTOR, factors[p]);
            write_cfg(CFG_DIMENSIONS, {{(FACTOR_W - DIMS_W){1'b0}}, dims[p]});
            if (p == 1) hold_req = 1'b1;
            phase_start = items_sent;
            while (items_sent - phase_start < RANDOM_ITEMS / N_PHASES) begin
                r = $urandom_range(0, 99);
                if (p == 1) begin
                    n = MAX_VERTS;
                end else if (r < 10) begin
                    n = $urandom_range(MAX_VERTS + 1, MAX_VERTS + 4);
                end else if (r < 20) begin
                    n = 1;
                end else begin
                    n = $urandom_range(2, MAX_VERTS);
                end
                burst = (p == 1) || ($urandom_range(0, 5) == 0);
                send_element(n, burst);
                if ($urandom_range(0, 7) == 0) wait_drained();
            end
            wait_drained();
        end

        if (errors == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule
